>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// expects clk and rst_n in scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FRQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frq assertion failed");

// next-cycle implication
`define FRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frq assertion failed");

`endif

>>> rtl/frq_pkg.sv
// shared constants, codes and control structs of the framed record ring queue
// no dependencies
`timescale 1ns / 1ps

package frq_pkg;

    localparam int RING_BYTES = 1024;
    localparam int MAX_RECORD = 64;
    localparam int HDR_BYTES  = 4;

    localparam int POS_W  = $clog2(RING_BYTES);
    localparam int USE_W  = $clog2(RING_BYTES + 1);
    localparam int SZ_W   = (USE_W > 8) ? USE_W : 8;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;
    localparam int TOT_W  = 32;
    localparam int FILL_W = 11;
    localparam int IDX_W  = $clog2(HDR_BYTES);

    localparam logic [1:0] OP_HDR  = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    localparam logic [STAT_W-1:0] ST_BYTE   = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STAT_W-1:0] ST_WAIT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_END    = 3'd3;
    localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd4;
    localparam logic [STAT_W-1:0] ST_DROP   = 3'd5;

    typedef struct packed {
        logic              capture;
        logic              hdr_accept;
        logic              hdr_drop;
        logic              hdr_write;
        logic              data_write;
        logic              data_discard;
        logic              pop_start;
        logic              hdr_read;
        logic              pop_take;
        logic              pop_skip;
        logic              emit;
        logic              result_load;
        logic [STAT_W-1:0] code;
    } frq_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       owed_zero;
        logic       discarding;
        logic       hdr_fits;
        logic       committed_low;
        logic       done;
        logic       idx_last;
        logic       sz_fits;
        logic       sz_zero;
        logic       out_free;
        logic       emit_done;
    } frq_sts_t;

endpackage

>>> rtl/frq_ctrl.sv
// controller state machine of the framed record ring queue
// depends on frq_pkg; drives frq_datapath through frq_cmd_t
`timescale 1ns / 1ps

module frq_ctrl import frq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  frq_sts_t sts,
    output frq_cmd_t cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECIDE    = 4'd1;
    localparam logic [3:0] S_HDR_WR    = 4'd2;
    localparam logic [3:0] S_POP_CHECK = 4'd3;
    localparam logic [3:0] S_POP_HDR   = 4'd4;
    localparam logic [3:0] S_POP_LAST  = 4'd5;
    localparam logic [3:0] S_POP_EVAL  = 4'd6;
    localparam logic [3:0] S_EMIT      = 4'd7;
    localparam logic [3:0] S_RESULT    = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [STAT_W-1:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_DROP;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_RESULT;
                code_next  = ST_DROP;
                unique case (sts.op)
                    OP_HDR:
                    begin
                        if (sts.owed_zero && !sts.hdr_fits)
                            cmd.hdr_drop = 1'b1;
                        else if (sts.owed_zero)
                        begin
                            cmd.hdr_accept = 1'b1;
                            code_next      = ST_ACCEPT;
                            state_next     = S_HDR_WR;
                        end
                    end
                    OP_DATA:
                    begin
                        if (!sts.owed_zero && sts.discarding)
                            cmd.data_discard = 1'b1;
                        else if (!sts.owed_zero)
                        begin
                            cmd.data_write = 1'b1;
                            code_next      = ST_ACCEPT;
                        end
                    end
                    OP_POP:
                    begin
                        state_next = S_POP_CHECK;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_HDR_WR:
            begin
                cmd.hdr_write = 1'b1;
                if (sts.idx_last)
                    state_next = S_RESULT;
            end
            S_POP_CHECK:
            begin
                if (sts.committed_low)
                begin
                    code_next  = sts.done ? ST_END : ST_WAIT;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.pop_start = 1'b1;
                    state_next    = S_POP_HDR;
                end
            end
            S_POP_HDR:
            begin
                cmd.hdr_read = 1'b1;
                if (sts.idx_last)
                    state_next = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                state_next = S_POP_EVAL;
            end
            S_POP_EVAL:
            begin
                if (sts.sz_fits)
                begin
                    cmd.pop_take = 1'b1;
                    if (sts.sz_zero)
                    begin
                        code_next  = ST_EMPTY;
                        state_next = S_RESULT;
                    end
                    else
                        state_next = S_EMIT;
                end
                else
                begin
                    cmd.pop_skip = 1'b1;
                    state_next   = S_POP_CHECK;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (sts.emit_done)
                    state_next = S_IDLE;
            end
            S_RESULT:
            begin
                cmd.result_load = 1'b1;
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/frq_datapath.sv
// datapath of the framed record ring queue: ring memory, pointers, totals, result register
// depends on frq_pkg; commanded by frq_ctrl
`timescale 1ns / 1ps

module frq_datapath import frq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  frq_cmd_t            cmd,
    output frq_sts_t            sts,
    input  logic [1:0]          operation,
    input  logic [LEN_W-1:0]    record_length,
    input  logic [BYTE_W-1:0]   byte_value,
    input  logic [LEN_W-1:0]    out_capacity,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                producer_done,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STAT_W-1:0]   status,
    output logic [BYTE_W-1:0]   data_byte,
    output logic                last_of_run,
    output logic [LEN_W-1:0]    popped_length,
    output logic [TOT_W-1:0]    dropped_count,
    output logic [TOT_W-1:0]    pushed_count,
    output logic [TOT_W-1:0]    popped_count,
    output logic [FILL_W-1:0]   bytes_in_use
);

    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
        next_pos = (p == POS_W'(RING_BYTES - 1)) ? '0 : p + POS_W'(1);
    endfunction

    logic [BYTE_W-1:0] ring_mem [RING_BYTES];

    // item held for the current transaction
    logic [1:0]        op_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BYTE_W-1:0] bv_reg;
    logic [LEN_W-1:0]  cap_reg;

    logic [POS_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [POS_W-1:0]  rd_pos_reg, rd_pos_next;
    logic [USE_W-1:0]  reserved_reg, reserved_next;
    logic [USE_W-1:0]  committed_reg, committed_next;
    logic [LEN_W-1:0]  owed_reg, owed_next;
    logic              discard_reg, discard_next;
    logic [TOT_W-1:0]  drop_reg, drop_next;
    logic [TOT_W-1:0]  push_reg, push_next;
    logic [TOT_W-1:0]  pop_reg, pop_next;
    logic              done_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              acc_pend_reg;
    logic [IDX_W-1:0]  acc_idx_reg;
    logic [BYTE_W-1:0] sz_low_reg;
    logic              sz_big_reg;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  emit_len_reg;
    logic              pend_reg, pend_next;
    logic [BYTE_W-1:0] rdata_reg;
    logic              out_valid_reg, out_valid_next;

    logic [STAT_W-1:0] status_reg;
    logic [BYTE_W-1:0] data_byte_reg;
    logic              last_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [TOT_W-1:0]  drop_out_reg, push_out_reg, pop_out_reg;
    logic [USE_W-1:0]  use_out_reg;

    logic [USE_W:0]    room_sum;
    logic              hdr_fits;
    logic [USE_W-1:0]  avail;
    logic [SZ_W-1:0]   avail_w, low_w, sz_eff;
    logic              sz_fits;
    logic [USE_W-1:0]  take_amt;
    logic [USE_W:0]    skip_sum;
    logic [POS_W-1:0]  skip_pos;
    logic              out_free, fire, issue, rd_en, wr_en, load_res, load_any;
    logic [BYTE_W-1:0] wr_data;

    assign room_sum = (USE_W+1)'(reserved_reg) + (USE_W+1)'(HDR_BYTES)
                    + (USE_W+1)'(len_reg);
    assign hdr_fits = (len_reg <= LEN_W'(MAX_RECORD))
                   && (room_sum <= (USE_W+1)'(RING_BYTES));

    // header size, clamped to what is committed
    assign avail    = committed_reg - USE_W'(HDR_BYTES);
    assign avail_w  = SZ_W'(avail);
    assign low_w    = SZ_W'(sz_low_reg);
    assign sz_eff   = (sz_big_reg || (low_w > avail_w)) ? avail_w : low_w;
    assign sz_fits  = (sz_eff <= SZ_W'(cap_reg)) && (sz_eff <= SZ_W'(MAX_RECORD));
    assign take_amt = USE_W'(sz_eff) + USE_W'(HDR_BYTES);
    assign skip_sum = (USE_W+1)'(rd_pos_reg) + (USE_W+1)'(sz_eff);
    assign skip_pos = (skip_sum >= (USE_W+1)'(RING_BYTES))
                    ? POS_W'(skip_sum - (USE_W+1)'(RING_BYTES)) : POS_W'(skip_sum);

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = cmd.emit && pend_reg && out_free;
    assign issue    = cmd.emit && (rem_reg != '0) && (!pend_reg || fire);
    assign rd_en    = cmd.hdr_read || issue;
    assign wr_en    = cmd.hdr_write || cmd.data_write;
    assign wr_data  = cmd.data_write ? bv_reg
                    : ((idx_reg == '0) ? BYTE_W'(len_reg) : '0);
    assign load_res = cmd.result_load && out_free;
    assign load_any = load_res || fire;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[wr_pos_reg] <= wr_data;
        if (rd_en)
            rdata_reg <= ring_mem[rd_pos_reg];
    end

    always_comb
    begin
        wr_pos_next    = wr_pos_reg;
        rd_pos_next    = rd_pos_reg;
        reserved_next  = reserved_reg;
        committed_next = committed_reg;
        owed_next      = owed_reg;
        discard_next   = discard_reg;
        drop_next      = drop_reg;
        push_next      = push_reg;
        pop_next       = pop_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;

        if (cmd.hdr_accept)
        begin
            reserved_next = USE_W'(room_sum);
            push_next     = push_reg + TOT_W'(1);
            owed_next     = len_reg;
            discard_next  = 1'b0;
            idx_next      = '0;
            if (len_reg == '0)
                committed_next = USE_W'(room_sum);
        end
        if (cmd.hdr_drop)
        begin
            drop_next    = drop_reg + TOT_W'(1);
            owed_next    = len_reg;
            discard_next = (len_reg != '0);
        end
        if (cmd.data_discard)
        begin
            owed_next = owed_reg - LEN_W'(1);
            if (owed_reg == LEN_W'(1))
                discard_next = 1'b0;
        end
        if (cmd.data_write)
        begin
            owed_next = owed_reg - LEN_W'(1);
            if (owed_reg == LEN_W'(1))
                committed_next = reserved_reg;
        end
        if (wr_en)
            wr_pos_next = next_pos(wr_pos_reg);
        if (cmd.hdr_write || cmd.hdr_read)
            idx_next = idx_reg + IDX_W'(1);
        if (cmd.pop_start)
            idx_next = '0;
        if (rd_en)
            rd_pos_next = next_pos(rd_pos_reg);
        if (cmd.pop_take || cmd.pop_skip)
        begin
            committed_next = committed_reg - take_amt;
            reserved_next  = reserved_reg - take_amt;
        end
        if (cmd.pop_take)
        begin
            pop_next = pop_reg + TOT_W'(1);
            rem_next = LEN_W'(sz_eff);
        end
        if (cmd.pop_skip)
        begin
            drop_next   = drop_reg + TOT_W'(1);
            rd_pos_next = skip_pos;
        end
        if (issue)
            rem_next = rem_reg - LEN_W'(1);
        if (issue)
            pend_next = 1'b1;
        else if (fire)
            pend_next = 1'b0;
    end

    always_comb
    begin
        if (load_any)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg    <= '0;
            rd_pos_reg    <= '0;
            reserved_reg  <= '0;
            committed_reg <= '0;
            owed_reg      <= '0;
            discard_reg   <= 1'b0;
            drop_reg      <= '0;
            push_reg      <= '0;
            pop_reg       <= '0;
            done_reg      <= 1'b0;
            idx_reg       <= '0;
            acc_pend_reg  <= 1'b0;
            rem_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_pos_reg    <= wr_pos_next;
            rd_pos_reg    <= rd_pos_next;
            reserved_reg  <= reserved_next;
            committed_reg <= committed_next;
            owed_reg      <= owed_next;
            discard_reg   <= discard_next;
            drop_reg      <= drop_next;
            push_reg      <= push_next;
            pop_reg       <= pop_next;
            idx_reg       <= idx_next;
            acc_pend_reg  <= cmd.hdr_read;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                done_reg <= producer_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            len_reg <= record_length;
            bv_reg  <= byte_value;
            cap_reg <= out_capacity;
        end
        acc_idx_reg <= idx_reg;
        // gather the length header one byte at a time
        if (acc_pend_reg)
        begin
            if (acc_idx_reg == '0)
            begin
                sz_low_reg <= rdata_reg;
                sz_big_reg <= 1'b0;
            end
            else if (rdata_reg != '0)
                sz_big_reg <= 1'b1;
        end
        if (cmd.pop_take)
            emit_len_reg <= LEN_W'(sz_eff);
        if (load_any)
        begin
            status_reg    <= fire ? ST_BYTE : cmd.code;
            data_byte_reg <= fire ? rdata_reg : '0;
            last_reg      <= fire ? (rem_reg == '0) : 1'b1;
            plen_reg      <= fire ? emit_len_reg : '0;
            drop_out_reg  <= drop_reg;
            push_out_reg  <= push_reg;
            pop_out_reg   <= pop_reg;
            use_out_reg   <= reserved_reg;
        end
    end

    assign sts.op            = op_reg;
    assign sts.owed_zero     = (owed_reg == '0);
    assign sts.discarding    = discard_reg;
    assign sts.hdr_fits      = hdr_fits;
    assign sts.committed_low = (committed_reg < USE_W'(HDR_BYTES));
    assign sts.done          = done_reg;
    assign sts.idx_last      = (idx_reg == IDX_W'(HDR_BYTES - 1));
    assign sts.sz_fits       = sz_fits;
    assign sts.sz_zero       = (sz_eff == '0);
    assign sts.out_free      = out_free;
    assign sts.emit_done     = (rem_reg == '0) && !pend_reg;

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign data_byte     = data_byte_reg;
    assign last_of_run   = last_reg;
    assign popped_length = plen_reg;
    assign dropped_count = drop_out_reg;
    assign pushed_count  = push_out_reg;
    assign popped_count  = pop_out_reg;
    assign bytes_in_use  = FILL_W'(use_out_reg);

endmodule

>>> rtl/framed_record_ring_queue_core.sv
// top level of the framed record ring queue
// depends on frq_pkg, frq_ctrl and frq_datapath
`timescale 1ns / 1ps

// Byte ring of length-prefixed records held in one 1024 x 8 memory with one write
// and one registered read per cycle. One transaction is worked on at a time; the
// next is taken once the previous one's last result sits in the output register.
// A push header writes its four header bytes through the single write port. A pop
// reads and checks each length header through the read port, does so again for
// every oversize record it skips, then streams the record at one byte per cycle
// while out_ready stays high. The memory is not cleared after reset; only bytes
// already written are read.
module framed_record_ring_queue_core import frq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [LEN_W-1:0]    record_length,
    input  logic [BYTE_W-1:0]   byte_value,
    input  logic [LEN_W-1:0]    out_capacity,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                producer_done,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STAT_W-1:0]   status,
    output logic [BYTE_W-1:0]   data_byte,
    output logic                last_of_run,
    output logic [LEN_W-1:0]    popped_length,
    output logic [TOT_W-1:0]    dropped_count,
    output logic [TOT_W-1:0]    pushed_count,
    output logic [TOT_W-1:0]    popped_count,
    output logic [FILL_W-1:0]   bytes_in_use
);

    frq_cmd_t cmd;
    frq_sts_t sts;

    frq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    frq_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .operation     (operation),
        .record_length (record_length),
        .byte_value    (byte_value),
        .out_capacity  (out_capacity),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .producer_done (producer_done),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_byte     (data_byte),
        .last_of_run   (last_of_run),
        .popped_length (popped_length),
        .dropped_count (dropped_count),
        .pushed_count  (pushed_count),
        .popped_count  (popped_count),
        .bytes_in_use  (bytes_in_use)
    );

endmodule

>>> rtl/frq_checker.sv
// port-level checks for framed_record_ring_queue_core, attached by bind
// depends on frq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frq_checker import frq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STAT_W-1:0]   status,
    input logic [BYTE_W-1:0]   data_byte,
    input logic                last_of_run,
    input logic [LEN_W-1:0]    popped_length,
    input logic [FILL_W-1:0]   bytes_in_use
);

    // a pending result holds until taken
    `FRQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
    // only record bytes carry data and a length
    `FRQ_ASSERT_NOW(a_plain_zero, out_valid && (status != ST_BYTE),
        (data_byte == '0) && (popped_length == '0) && last_of_run)
    // record bytes carry a legal length
    `FRQ_ASSERT_NOW(a_byte_len, out_valid && (status == ST_BYTE),
        (popped_length != '0) && (popped_length <= LEN_W'(MAX_RECORD)))
    // ring occupancy never exceeds the ring
    `FRQ_ASSERT_NOW(a_fill, out_valid, bytes_in_use <= FILL_W'(RING_BYTES))

endmodule

bind framed_record_ring_queue_core frq_checker u_frq_checker (.*);

>>> dv/tb_framed_record_ring_queue_core.sv
// self-checking testbench for framed_record_ring_queue_core: random and directed
// push/pop traffic, an in-bench model of the record ring, per-field result checks
// depends on frq_pkg and the rtl of the record ring queue
`timescale 1ns / 1ps

module tb_framed_record_ring_queue_core;
    import frq_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         TAIL_CYCLES = 100;

    typedef struct {
        logic [1:0]        op;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] bval;
        logic [LEN_W-1:0]  cap;
    } ring_req_t;

    typedef struct {
        logic [STAT_W-1:0] st;
        logic [BYTE_W-1:0] dbyte;
        logic              last;
        logic [LEN_W-1:0]  plen;
        logic [TOT_W-1:0]  drops;
        logic [TOT_W-1:0]  pushes;
        logic [TOT_W-1:0]  pops;
        logic [FILL_W-1:0] fill;
    } ring_reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          operation = OP_HDR;
    logic [LEN_W-1:0]    record_length = '0;
    logic [BYTE_W-1:0]   byte_value = '0;
    logic [LEN_W-1:0]    out_capacity = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                producer_done = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STAT_W-1:0]   status;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_of_run;
    logic [LEN_W-1:0]    popped_length;
    logic [TOT_W-1:0]    dropped_count;
    logic [TOT_W-1:0]    pushed_count;
    logic [TOT_W-1:0]    popped_count;
    logic [FILL_W-1:0]   bytes_in_use;

    ring_req_t   req_q[$];
    ring_reply_t reply_q[$];
    ring_req_t   cur_req;
    ring_reply_t exp_r;

    // model of the ring
    logic [7:0]        ring_copy [RING_BYTES];
    int unsigned       m_wr = 0;
    int unsigned       m_rd = 0;
    int unsigned       m_resv = 0;
    int unsigned       m_comm = 0;
    int unsigned       m_owed = 0;
    bit                m_discard = 1'b0;
    logic [TOT_W-1:0]  m_drops = '0;
    logic [TOT_W-1:0]  m_pushes = '0;
    logic [TOT_W-1:0]  m_pops = '0;
    bit                m_done = 1'b0;

    bit in_idle_on = 1'b1;
    bit out_idle_on = 1'b1;
    int in_gap = 0;
    int out_stall = 0;
    int mismatches = 0;
    int cycle_count = 0;

    framed_record_ring_queue_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .record_length (record_length),
        .byte_value    (byte_value),
        .out_capacity  (out_capacity),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .producer_done (producer_done),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_byte     (data_byte),
        .last_of_run   (last_of_run),
        .popped_length (popped_length),
        .dropped_count (dropped_count),
        .pushed_count  (pushed_count),
        .popped_count  (popped_count),
        .bytes_in_use  (bytes_in_use)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned next_pos(int unsigned p);
        return (p + 1 >= RING_BYTES) ? 0 : p + 1;
    endfunction

    task automatic add_reply(logic [STAT_W-1:0] st, logic [BYTE_W-1:0] b, logic last,
                             int unsigned plen);
        ring_reply_t r;
        r.st     = st;
        r.dbyte  = b;
        r.last   = last;
        r.plen   = plen[LEN_W-1:0];
        r.drops  = m_drops;
        r.pushes = m_pushes;
        r.pops   = m_pops;
        r.fill   = m_resv[FILL_W-1:0];
        reply_q.push_back(r);
    endtask

    task automatic predict_replies(ring_req_t r);
        int unsigned sz;
        int unsigned avail;
        int          i;
        bit          popping;
        case (r.op)
            OP_HDR:
            begin
                if (m_owed != 0)
                begin
                    add_reply(ST_DROP, 8'd0, 1'b1, 0);
                end
                else if (r.len > MAX_RECORD || RING_BYTES - m_resv < HDR_BYTES + r.len)
                begin
                    m_drops++;
                    m_owed = r.len;
                    m_discard = (r.len != 0);
                    add_reply(ST_DROP, 8'd0, 1'b1, 0);
                end
                else
                begin
                    for (i = 0; i < HDR_BYTES; i++)
                    begin
                        ring_copy[m_wr] = 8'((32'(r.len)) >> (8 * i));
                        m_wr = next_pos(m_wr);
                    end
                    m_resv += HDR_BYTES + r.len;
                    m_pushes++;
                    m_owed = r.len;
                    m_discard = 1'b0;
                    if (r.len == 0)
                        m_comm = m_resv;
                    add_reply(ST_ACCEPT, 8'd0, 1'b1, 0);
                end
            end
            OP_DATA:
            begin
                if (m_owed == 0)
                begin
                    add_reply(ST_DROP, 8'd0, 1'b1, 0);
                end
                else
                begin
                    m_owed--;
                    if (m_discard)
                    begin
                        if (m_owed == 0)
                            m_discard = 1'b0;
                        add_reply(ST_DROP, 8'd0, 1'b1, 0);
                    end
                    else
                    begin
                        ring_copy[m_wr] = r.bval;
                        m_wr = next_pos(m_wr);
                        if (m_owed == 0)
                            m_comm = m_resv;
                        add_reply(ST_ACCEPT, 8'd0, 1'b1, 0);
                    end
                end
            end
            OP_POP:
            begin
                popping = 1'b1;
                while (popping)
                begin
                    if (m_comm < HDR_BYTES)
                    begin
                        add_reply(m_done ? ST_END : ST_WAIT, 8'd0, 1'b1, 0);
                        popping = 1'b0;
                    end
                    else
                    begin
                        sz = 0;
                        for (i = 0; i < HDR_BYTES; i++)
                        begin
                            sz |= 32'(ring_copy[m_rd]) << (8 * i);
                            m_rd = next_pos(m_rd);
                        end
                        avail = m_comm - HDR_BYTES;
                        if (sz > avail)
                            sz = avail;
                        m_comm -= HDR_BYTES + sz;
                        m_resv -= HDR_BYTES + sz;
                        if (sz <= r.cap && sz <= MAX_RECORD)
                        begin
                            m_pops++;
                            if (sz == 0)
                                add_reply(ST_EMPTY, 8'd0, 1'b1, 0);
                            for (i = 0; i < sz; i++)
                            begin
                                add_reply(ST_BYTE, ring_copy[m_rd], (i + 1 == sz), sz);
                                m_rd = next_pos(m_rd);
                            end
                            popping = 1'b0;
                        end
                        else
                        begin
                            // oversize for this popper: skip the whole record
                            m_rd = (m_rd + sz) % RING_BYTES;
                            m_drops++;
                        end
                    end
                end
            end
            default:
            begin
                add_reply(ST_DROP, 8'd0, 1'b1, 0);
            end
        endcase
    endtask

    // val is the field that the operation uses, the others get random values
    task automatic queue_req(logic [1:0] op, int unsigned val);
        ring_req_t r;
        r.op   = op;
        r.len  = $urandom_range(0, 127);
        r.bval = $urandom_range(0, 255);
        r.cap  = $urandom_range(0, 127);
        case (op)
            OP_HDR:  r.len = val[LEN_W-1:0];
            OP_DATA: r.bval = val[BYTE_W-1:0];
            OP_POP:  r.cap = val[LEN_W-1:0];
            default: ;
        endcase
        req_q.push_back(r);
    endtask

    task automatic wait_idle();
        while (req_q.size() != 0 || in_valid || reply_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_producer_done(bit v);
        @(posedge clk);
        cfg_valid     <= 1'b1;
        producer_done <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        m_done = v;
    endtask

    task automatic gen_traffic(int budget);
        int n;
        int pick;
        int len;
        int cut;
        int i;
        n = 0;
        while (n < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                pick = $urandom_range(0, 99);
                len = (pick < 6) ? $urandom_range(MAX_RECORD + 1, MAX_RECORD + 8) :
                      (pick < 10) ? MAX_RECORD : $urandom_range(0, 12);
                // now and then break the record with a header or pop in the middle
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
                queue_req(OP_HDR, len);
                for (i = 0; i < len; i++)
                begin
                    if (i == cut)
                    begin
                        queue_req($urandom_range(0, 1) ? OP_HDR : OP_POP,
                                  $urandom_range(0, MAX_RECORD));
                        n++;
                    end
                    queue_req(OP_DATA, $urandom_range(0, 255));
                end
                n += 1 + len;
            end
            else if (pick < 85)
            begin
                pick = $urandom_range(0, 9);
                queue_req(OP_POP, (pick < 7) ? MAX_RECORD :
                                  (pick < 9) ? $urandom_range(0, 12) : $urandom_range(0, 127));
                n++;
            end
            else
            begin
                queue_req($urandom_range(0, 1) ? OP_DATA : OP_UNUSED, $urandom_range(0, 255));
                n++;
            end
        end
    endtask

    task automatic drain_ring();
        int i;
        while (m_resv != 0)
        begin
            for (i = 0; i < 8; i++)
                queue_req(OP_POP, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : 127);
            wait_idle();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_replies(cur_req);
                in_gap = in_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (req_q.size() > 0)
                begin
                    cur_req = req_q.pop_front();
                    in_valid      <= 1'b1;
                    operation     <= cur_req.op;
                    record_length <= cur_req.len;
                    byte_value    <= cur_req.bval;
                    out_capacity  <= cur_req.cap;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected 0x%0h got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("unexpected result with status %0d", status);
                    mismatches++;
                end
                else
                begin
                    exp_r = reply_q.pop_front();
                    check_field("status", exp_r.st, status);
                    check_field("data_byte", exp_r.dbyte, data_byte);
                    check_field("last_of_run", exp_r.last, last_of_run);
                    check_field("popped_length", exp_r.plen, popped_length);
                    check_field("dropped_count", exp_r.drops, dropped_count);
                    check_field("pushed_count", exp_r.pushes, pushed_count);
                    check_field("popped_count", exp_r.pops, popped_count);
                    check_field("bytes_in_use", exp_r.fill, bytes_in_use);
                end
                out_stall = out_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int c;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_producer_done(1'b0);

        // directed: empty ring, stray byte, unknown op, zero-length record,
        // header while bytes owed, incomplete head, oversize skip, small record
        queue_req(OP_POP, MAX_RECORD);
        queue_req(OP_DATA, 8'hFF);
        queue_req(OP_UNUSED, 0);
        queue_req(OP_HDR, 0);
        queue_req(OP_POP, 0);
        queue_req(OP_HDR, 2);
        queue_req(OP_HDR, 1);
        queue_req(OP_DATA, 8'h00);
        queue_req(OP_POP, MAX_RECORD);
        queue_req(OP_DATA, 8'hFF);
        queue_req(OP_POP, 1);
        queue_req(OP_HDR, 3);
        queue_req(OP_DATA, 8'hA5);
        queue_req(OP_DATA, 8'h5A);
        queue_req(OP_DATA, 8'h01);
        queue_req(OP_POP, 3);
        queue_req(OP_POP, 127);
        wait_idle();

        write_producer_done(1'b1);
        queue_req(OP_POP, MAX_RECORD);
        queue_req(OP_HDR, 1);
        queue_req(OP_POP, MAX_RECORD);
        queue_req(OP_DATA, 8'h80);
        queue_req(OP_POP, 127);
        queue_req(OP_POP, 127);
        wait_idle();

        // oversize header with its discarded bytes, then a stray byte
        write_producer_done(1'b0);
        queue_req(OP_HDR, MAX_RECORD + 1);
        queue_req(OP_HDR, 0);
        for (c = 0; c < MAX_RECORD + 1; c++)
            queue_req(OP_DATA, $urandom_range(0, 255));
        queue_req(OP_DATA, $urandom_range(0, 255));
        queue_req(OP_POP, MAX_RECORD);
        wait_idle();

        for (c = 0; c < 2; c++)
        begin
            write_producer_done((c % 2) != 0);
            in_idle_on  = (c != 1) && ($urandom_range(0, 3) != 0);
            out_idle_on = (c != 1) && ($urandom_range(0, 3) != 0);
            gen_traffic(20);
            wait_idle();
        end

        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        write_producer_done(1'b1);
        drain_ring();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (reply_q.size() != 0)
        begin
            $error("%0d expected results never arrived", reply_q.size());
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
